FILE: hw/rtl/double_ended_queue_macros.svh
// ----------------------------------------------------------------------------
// double_ended_queue_macros
// assertion macros for the deque datapath; empty bodies for synthesis
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define DEQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("deque assertion failed");

// condition must never be seen outside reset
`define DEQ_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("deque forbidden condition seen");

`else

`define DEQ_ASSERT(lbl, clk, rst, prop)
`define DEQ_ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

FILE: hw/rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// shared types, codes and constants of the double-ended queue
// ----------------------------------------------------------------------------
package deq_pkg;

   // default ring capacity
   localparam int DEFAULT_CAPACITY = 16;

   // fixed field widths
   localparam int VALUE_W  = 32;
   localparam int OPCODE_W = 2;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   // request operations
   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_BACK  = 2'd0,
      OP_POP_BACK   = 2'd1,
      OP_PUSH_FRONT = 2'd2,
      OP_POP_FRONT  = 2'd3
   } opcode_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LOAD
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic latch_req;
      logic exec;
      logic load_rsp;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

FILE: hw/rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// sequencer: accept a transaction, execute it, hand the result to the
// output register
// ----------------------------------------------------------------------------
module deq_ctrl
   import deq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.latch_req = 1'b0;
      cmd.exec      = 1'b0;
      cmd.load_rsp  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (stat.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/deq_datapath.sv
// ----------------------------------------------------------------------------
// deq_datapath
// ring store, head pointer, entry count and response register
// ----------------------------------------------------------------------------
`include "double_ended_queue_macros.svh"

module deq_datapath
   import deq_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output stat_type                   stat,
   input  logic [OPCODE_W-1:0]        req_opcode,
   input  logic signed [VALUE_W-1:0]  req_push_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [VALUE_W-1:0]  rsp_popped_value,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [OCC_W-1:0]           rsp_occupancy
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = IDX_W + 1;
   localparam logic [SUM_W-1:0] CAP_S   = SUM_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_C   = CNT_W'(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(CAPACITY - 1);

   // ring store
   logic [VALUE_W-1:0] mem [CAPACITY];
   logic [VALUE_W-1:0] rdata_ff;

   // latched request
   opcode_type         op_ff;
   logic [VALUE_W-1:0] value_ff;

   // queue state
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // execute results
   status_type         status_ff;
   logic               pop_ok_ff;

   // response register
   logic                      rsp_valid_ff;
   logic signed [VALUE_W-1:0] rsp_popped_ff;
   status_type                rsp_status_ff;
   logic [OCC_W-1:0]          rsp_occ_ff;

   logic               is_push;
   logic               ok;
   logic [SUM_W-1:0]   cnt_s;
   logic [SUM_W-1:0]   offset;
   logic [SUM_W-1:0]   back_sum;
   logic [SUM_W-1:0]   back_wrap;
   logic [IDX_W-1:0]   head_dec;
   logic [IDX_W-1:0]   head_inc;
   logic [IDX_W-1:0]   slot;
   status_type         status_now;

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff    <= opcode_type'(req_opcode);
         value_ff <= req_push_value;
      end
   end

   // operation decode, full and empty checks
   always_comb begin
      is_push = (op_ff == OP_PUSH_BACK) || (op_ff == OP_PUSH_FRONT);
      if (is_push) begin
         ok         = (count_ff != CAP_C);
         status_now = ok ? ST_OK : ST_FULL;
      end else begin
         ok         = (count_ff != '0);
         status_now = ok ? ST_OK : ST_EMPTY;
      end
   end

   // slot address: back slot is head plus count (less one for a pop), wrapped once
   always_comb begin
      cnt_s     = SUM_W'(count_ff);
      offset    = is_push ? cnt_s : (cnt_s - SUM_W'(1));
      back_sum  = {1'b0, head_ff} + offset;
      back_wrap = (back_sum >= CAP_S) ? (back_sum - CAP_S) : back_sum;
      head_dec  = (head_ff == '0) ? LAST_IX : (head_ff - IDX_W'(1));
      head_inc  = (head_ff == LAST_IX) ? '0 : (head_ff + IDX_W'(1));
      case (op_ff)
         OP_PUSH_BACK:  slot = back_wrap[IDX_W-1:0];
         OP_POP_BACK:   slot = back_wrap[IDX_W-1:0];
         OP_PUSH_FRONT: slot = head_dec;
         OP_POP_FRONT:  slot = head_ff;
         default:       slot = head_ff;
      endcase
   end

   // head and count update
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.exec && ok) begin
         case (op_ff)
            OP_PUSH_BACK:  count_in = count_ff + CNT_W'(1);
            OP_POP_BACK:   count_in = count_ff - CNT_W'(1);
            OP_PUSH_FRONT: begin
               head_in  = head_dec;
               count_in = count_ff + CNT_W'(1);
            end
            OP_POP_FRONT: begin
               head_in  = head_inc;
               count_in = count_ff - CNT_W'(1);
            end
            default: begin
               head_in  = head_ff;
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // store write and registered read
   always_ff @(posedge clock) begin
      if (cmd.exec && ok && is_push) begin
         mem[slot] <= value_ff;
      end
      if (cmd.exec && !is_push) begin
         rdata_ff <= mem[slot];
      end
   end

   // execute outcome
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_now;
         pop_ok_ff <= ok && !is_push;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_popped_ff <= pop_ok_ff ? signed'(rdata_ff) : '0;
         rsp_status_ff <= status_ff;
         rsp_occ_ff    <= OCC_W'(count_ff);
      end
   end

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign stat.out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_popped_value  = rsp_popped_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_occupancy     = rsp_occ_ff;

   // checks
   `DEQ_ASSERT_NEVER(a_count_range, clock, reset, count_ff > CAP_C)
   `DEQ_ASSERT_NEVER(a_head_range, clock, reset, {1'b0, head_ff} >= CAP_S)
   `DEQ_ASSERT(a_push_grows, clock, reset, (cmd.exec && ok && is_push) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
   `DEQ_ASSERT(a_fail_holds, clock, reset, (cmd.exec && !ok) |=> ($stable(count_ff) && $stable(head_ff)))
   `DEQ_ASSERT_NEVER(a_load_while_busy, clock, reset, cmd.load_rsp && rsp_valid_ff && !rsp_ready)

endmodule

FILE: hw/rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// double-ended queue of signed 32-bit words in a ring store with push and
// pop at both ends
// ----------------------------------------------------------------------------
//  channel  ports                                  direction
//  req      req_valid/ready, opcode, push_value    in
//  rsp      rsp_valid/ready, popped_value, status, out
//           occupancy
//
//  each transaction steps through latch, execute (store write or read
//  address) and load into the response register
//  a new request is taken while the previous response still waits
//  a stalled response holds the sequencer in its load step
//  reset clears head pointer, count and response valid; no store clearing
// ----------------------------------------------------------------------------
module double_ended_queue
   import deq_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [OPCODE_W-1:0]        req_opcode,
   input  logic signed [VALUE_W-1:0]  req_push_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [VALUE_W-1:0]  rsp_popped_value,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [OCC_W-1:0]           rsp_occupancy
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // ring store and pointers
   deq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_opcode       (req_opcode),
      .req_push_value   (req_push_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_popped_value (rsp_popped_value),
      .rsp_status       (rsp_status),
      .rsp_occupancy    (rsp_occupancy)
   );

endmodule

FILE: tb/double_ended_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// checks every response of the deque against a mirror of its ring store;
// directed corner cases, then biased random push/pop phases with random
// stalls on both channels and long response back-pressure
// ----------------------------------------------------------------------------
module double_ended_queue_tb
   import deq_pkg::*;
();

   localparam int DEPTH = DEFAULT_CAPACITY;

   // one response as the deque should return it
   typedef struct packed {
      logic signed [VALUE_W-1:0] popped;
      status_type                status;
      logic [OCC_W-1:0]          occupancy;
   } deque_response_type;

   // mirror of the ring store plus the responses still owed by the block
   class deque_scoreboard;
      logic signed [VALUE_W-1:0] ring[DEPTH];
      int unsigned               front_slot;
      int unsigned               held;
      deque_response_type        owed_responses[$];
      int                        failures;

      function new();
         front_slot = 0;
         held       = 0;
         failures   = 0;
      endfunction

      function int unsigned wrap(input int unsigned pos);
         return (pos >= DEPTH) ? pos - DEPTH : pos;
      endfunction

      // apply an accepted request to the mirror and queue its response
      function void apply_request(input opcode_type op,
                                  input logic signed [VALUE_W-1:0] word);
         deque_response_type rsp;
         rsp.popped = '0;
         rsp.status = ST_OK;
         case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
               if (held >= DEPTH) begin
                  rsp.status = ST_FULL;
               end else if (op == OP_PUSH_BACK) begin
                  ring[wrap(front_slot + held)] = word;
                  held++;
               end else begin
                  front_slot = wrap(front_slot + DEPTH - 1);
                  ring[front_slot] = word;
                  held++;
               end
            end
            default: begin
               if (held == 0) begin
                  rsp.status = ST_EMPTY;
               end else if (op == OP_POP_BACK) begin
                  rsp.popped = ring[wrap(front_slot + held - 1)];
                  held--;
               end else begin
                  rsp.popped = ring[front_slot];
                  front_slot = wrap(front_slot + 1);
                  held--;
               end
            end
         endcase
         rsp.occupancy = held[OCC_W-1:0];
         owed_responses.push_back(rsp);
      endfunction

      // compare a returned response with the oldest one owed
      function void check_response(input logic signed [VALUE_W-1:0] popped,
                                   input logic [STATUS_W-1:0] status,
                                   input logic [OCC_W-1:0] occupancy);
         deque_response_type want;
         if (owed_responses.size() == 0) begin
            $error("response with no request outstanding: popped %0d status %0d",
                   popped, status);
            failures++;
            return;
         end
         want = owed_responses.pop_front();
         if (popped !== want.popped) begin
            $error("popped_value: expected %0d, actual %0d", want.popped, popped);
            failures++;
         end
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            failures++;
         end
         if (occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", want.occupancy, occupancy);
            failures++;
         end
      endfunction

      function int pending();
         return owed_responses.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [OPCODE_W-1:0]       req_opcode = OP_PUSH_BACK;
   logic signed [VALUE_W-1:0] req_push_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0] rsp_popped_value;
   logic [STATUS_W-1:0]       rsp_status;
   logic [OCC_W-1:0]          rsp_occupancy;

   deque_scoreboard sb = new();

   // stall controls of the driving processes
   bit sender_idle   = 1'b1;
   bit receiver_idle = 1'b1;
   int hold_off_cycles = 0;

   double_ended_queue uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_push_value   (req_push_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_popped_value (rsp_popped_value),
      .rsp_status       (rsp_status),
      .rsp_occupancy    (rsp_occupancy)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // observe both channels at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_popped_value, rsp_status, rsp_occupancy);
         if (req_valid && req_ready)
            sb.apply_request(opcode_type'(req_opcode), req_push_value);
      end
   end

   // offer one request transaction and wait for it to be taken
   task automatic send_request(input opcode_type op,
                               input logic signed [VALUE_W-1:0] word);
      int gap;
      gap = sender_idle ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_push_value <= word;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 32'sh7fff_ffff;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -1;
         4:       return $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   // response side: random stalls, idle-free stretches and long hold-offs
   initial begin
      int gap;
      int taken;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 40 == 0)
            receiver_idle = ($urandom_range(0, 3) != 0);
         gap = receiver_idle ? $urandom_range(0, 19) : 0;
         if (hold_off_cycles > 0) begin
            gap = gap + hold_off_cycles;
            hold_off_cycles = 0;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // stimulus
   initial begin
      int          i;
      int          push_bias;
      opcode_type  op;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pops on an empty queue, head wrap below slot zero, extreme words
      send_request(OP_POP_BACK, 32'sd5);
      send_request(OP_POP_FRONT, -32'sd5);
      send_request(OP_PUSH_FRONT, 32'sh7fff_ffff);
      send_request(OP_PUSH_BACK, 32'sh8000_0000);
      send_request(OP_POP_BACK, '0);
      send_request(OP_POP_FRONT, '0);
      // fill from both ends until full, then push on full
      for (i = 0; i < DEPTH; i++)
         send_request((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                      (i % 3 == 0) ? -1 : ((i % 3 == 1) ? 32'sh5555_aaaa : i));
      send_request(OP_PUSH_BACK, 32'sh1234_5678);
      send_request(OP_PUSH_FRONT, -32'sh1234_5678);
      send_request(OP_POP_FRONT, '0);

      // random phases biased toward filling, draining or balanced
      push_bias = 50;
      for (i = 0; i < 1550; i++) begin
         if (i % 50 == 0) begin
            sender_idle = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 2))
               0:       push_bias = 85;
               1:       push_bias = 15;
               default: push_bias = 50;
            endcase
         end
         // long response hold-off while requests keep coming back to back
         if (i == 400 || i == 1100) begin
            hold_off_cycles = 150;
            sender_idle = 1'b0;
         end
         if ($urandom_range(0, 99) < push_bias)
            op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
         else
            op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
         send_request(op, pick_word());
      end
      req_valid <= 1'b0;
      // let the monitor record the last accepted request first
      @(posedge clock);

      // drain and let any stray response show up
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // watchdog
   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
